>>> design/tsft_pkg.sv
// ----------------------------------------------------------------------------
// tsft_pkg
// Shared types and constants for the TDMA slot/frame/multiframe time base.
// ----------------------------------------------------------------------------
package tsft_pkg;

  localparam int unsigned SlotW  = 3;
  localparam int unsigned FrameW = 5;
  localparam int unsigned MfW    = 6;

  localparam logic [SlotW-1:0]  SlotsPerFrame = 3'd4;
  localparam logic [SlotW-1:0]  SlaveLag      = 3'd3;
  localparam logic [FrameW-1:0] FramesPerMf   = 5'd18;
  localparam logic [MfW-1:0]    MfPerHf       = 6'd60;

  localparam int unsigned InDataW  = 16;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 32;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_FULL   = 2'd1,
    REQ_MASTER = 2'd2,
    REQ_SLAVE  = 2'd3
  } tsft_req_e;

  typedef struct packed {
    logic [SlotW-1:0]  slot;
    logic [FrameW-1:0] frame;
    logic [MfW-1:0]    mf;
  } tsft_time_t;

  typedef struct packed {
    tsft_req_e   req_type;
    logic [1:0]  slot_in;
    logic [4:0]  frame_in;
    logic [5:0]  multiframe_in;
  } tsft_item_t;

  typedef struct packed {
    logic [SlotW-1:0]  slot_now;
    logic [FrameW-1:0] frame_now;
    logic [MfW-1:0]    multiframe_now;
    logic [SlotW-1:0]  slot_slave;
    logic [FrameW-1:0] frame_slave;
    logic              in_sync;
    logic              frame18;
    logic              sync_block_slot;
    logic              network_block_slot;
    logic              frame18_slave;
  } tsft_result_t;

endpackage

>>> design/tdma_slot_frame_timebase.sv
// ----------------------------------------------------------------------------
// tdma_slot_frame_timebase
// TDMA time base: slot 1..4, frame 1..18(19), multiframe 1..60, with resync.
// ----------------------------------------------------------------------------
// channel   dir  valid/ready                   payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: slot_in, frame_in, mf_in
//                                              tuser: req_type
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: time, slave time, marks
//
// One transfer in gives one transfer out; a transfer can be taken every cycle
// while the output is not stalled. Each transfer passes the input register,
// then the result register, with the time update done between them.
// Reset sets time 1/1/1 and clears the match flag; no clearing pass.
// A stalled output holds its result; the input register then refills once.
// ----------------------------------------------------------------------------
module tdma_slot_frame_timebase import tsft_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [1:0] slot_in, [6:2] frame_in, [12:7] multiframe_in, [15:13] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [1:0] req_type
  input  logic [InUserW-1:0]  s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [2:0] slot_now, [7:3] frame_now, [13:8] multiframe_now, [16:14] slot_slave,
  // [21:17] frame_slave, [22] in_sync, [23] frame18, [24] sync_block_slot,
  // [25] network_block_slot, [26] frame18_slave, [31:27] zero
  output logic [OutDataW-1:0] m_axis_tdata
);

  logic         in_v_q;
  tsft_item_t   in_q;
  logic         out_v_q;
  tsft_result_t out_q;
  tsft_time_t   time_q;
  tsft_time_t   time_d;
  logic         match_q;
  logic         match_d;
  tsft_result_t res;
  logic         adv;
  logic         take;

  assign adv           = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || adv;
  assign take          = s_axis_tvalid && s_axis_tready;

  tsft_core u_core (
    .item_i  (in_q),
    .cur_i   (time_q),
    .match_i (match_q),
    .nxt_o   (time_d),
    .match_o (match_d),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      time_q  <= '{slot: 3'd1, frame: 5'd1, mf: 6'd1};
      match_q <= 1'b0;
    end else begin
      if (take) begin
        in_v_q <= 1'b1;
      end else if (adv) begin
        in_v_q <= 1'b0;
      end
      if (adv) begin
        out_v_q <= 1'b1;
        time_q  <= time_d;
        match_q <= match_d;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q.req_type      <= tsft_req_e'(s_axis_tuser);
      in_q.slot_in       <= s_axis_tdata[1:0];
      in_q.frame_in      <= s_axis_tdata[6:2];
      in_q.multiframe_in <= s_axis_tdata[12:7];
    end
    if (adv) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {5'd0,
                          out_q.frame18_slave,
                          out_q.network_block_slot,
                          out_q.sync_block_slot,
                          out_q.frame18,
                          out_q.in_sync,
                          out_q.frame_slave,
                          out_q.slot_slave,
                          out_q.multiframe_now,
                          out_q.frame_now,
                          out_q.slot_now};

endmodule

>>> design/tsft_core.sv
// ----------------------------------------------------------------------------
// tsft_core
// Next-time logic: slot tick, full/master/slave resync, slave time and marks.
// ----------------------------------------------------------------------------
module tsft_core import tsft_pkg::*; (
  input  tsft_item_t   item_i,
  input  tsft_time_t   cur_i,
  input  logic         match_i,
  output tsft_time_t   nxt_o,
  output logic         match_o,
  output tsft_result_t res_o
);

  logic [SlotW-1:0]  tn;
  logic [FrameW-1:0] fn_clamp;
  logic [MfW-1:0]    mn_clamp;
  logic [SlotW-1:0]  slv_slot_cur;
  logic [FrameW-1:0] slv_frame_cur;
  logic [FrameW-1:0] tick_frame;
  logic [SlotW-1:0]  slv_sum;
  logic [SlotW-1:0]  slv_slot_nxt;
  logic [FrameW-1:0] slv_frame_nxt;
  logic [1:0]        mf_p1;
  logic [1:0]        mf_p3;
  logic              fr18;

  assign tn = {1'b0, item_i.slot_in} + 3'd1;

  always_comb begin
    if (item_i.frame_in == '0) begin
      fn_clamp = 5'd1;
    end else if (item_i.frame_in > FramesPerMf) begin
      fn_clamp = FramesPerMf;
    end else begin
      fn_clamp = item_i.frame_in;
    end
    if (item_i.multiframe_in == '0) begin
      mn_clamp = 6'd1;
    end else if (item_i.multiframe_in > MfPerHf) begin
      mn_clamp = MfPerHf;
    end else begin
      mn_clamp = item_i.multiframe_in;
    end
  end

  // slave time three slots behind the held time
  always_comb begin
    if (cur_i.slot < SlotsPerFrame) begin
      slv_slot_cur  = cur_i.slot + SlotsPerFrame - SlaveLag;
      slv_frame_cur = (cur_i.frame == 5'd1) ? FramesPerMf : cur_i.frame - 5'd1;
    end else begin
      slv_slot_cur  = cur_i.slot - SlaveLag;
      slv_frame_cur = cur_i.frame;
    end
  end

  assign tick_frame = (cur_i.slot == SlotsPerFrame) ? cur_i.frame + 5'd1 : cur_i.frame;
  assign slv_sum    = tn + SlaveLag;

  always_comb begin
    nxt_o   = cur_i;
    match_o = match_i;
    unique case (item_i.req_type)
      REQ_TICK: begin
        nxt_o.slot = (cur_i.slot == SlotsPerFrame) ? 3'd1 : cur_i.slot + 3'd1;
        if (tick_frame > FramesPerMf) begin
          nxt_o.frame = 5'd1;
          nxt_o.mf    = (cur_i.mf >= MfPerHf) ? 6'd1 : cur_i.mf + 6'd1;
        end else begin
          nxt_o.frame = tick_frame;
        end
      end
      REQ_FULL: begin
        match_o = (tn == cur_i.slot) && (item_i.frame_in == cur_i.frame) &&
                  (item_i.multiframe_in == cur_i.mf);
        nxt_o.slot  = tn;
        nxt_o.frame = fn_clamp;
        nxt_o.mf    = mn_clamp;
      end
      REQ_MASTER: begin
        match_o = (tn == cur_i.slot) && (item_i.frame_in == cur_i.frame);
        nxt_o.slot  = tn;
        nxt_o.frame = fn_clamp;
      end
      REQ_SLAVE: begin
        match_o = (tn == slv_slot_cur) && (item_i.frame_in == slv_frame_cur);
        if (slv_sum > SlotsPerFrame) begin
          nxt_o.slot  = slv_sum - SlotsPerFrame;
          nxt_o.frame = fn_clamp + 5'd1;
        end else begin
          nxt_o.slot  = slv_sum;
          nxt_o.frame = fn_clamp;
        end
      end
      default: begin
        nxt_o = cur_i;
      end
    endcase
  end

  always_comb begin
    if (nxt_o.slot < SlotsPerFrame) begin
      slv_slot_nxt  = nxt_o.slot + SlotsPerFrame - SlaveLag;
      slv_frame_nxt = (nxt_o.frame == 5'd1) ? FramesPerMf : nxt_o.frame - 5'd1;
    end else begin
      slv_slot_nxt  = nxt_o.slot - SlaveLag;
      slv_frame_nxt = nxt_o.frame;
    end
  end

  assign mf_p1 = nxt_o.mf[1:0] + 2'd1;
  assign mf_p3 = nxt_o.mf[1:0] + 2'd3;
  assign fr18  = (nxt_o.frame == FramesPerMf);

  always_comb begin
    res_o.slot_now           = nxt_o.slot;
    res_o.frame_now          = nxt_o.frame;
    res_o.multiframe_now     = nxt_o.mf;
    res_o.slot_slave         = slv_slot_nxt;
    res_o.frame_slave        = slv_frame_nxt;
    res_o.in_sync            = match_o;
    res_o.frame18            = fr18;
    res_o.sync_block_slot    = fr18 && (nxt_o.slot == SlotsPerFrame - {1'b0, mf_p1});
    res_o.network_block_slot = fr18 && (nxt_o.slot == SlotsPerFrame - {1'b0, mf_p3});
    res_o.frame18_slave      = (slv_frame_nxt == FramesPerMf);
  end

endmodule

>>> design/tsft_checker.sv
// ----------------------------------------------------------------------------
// tsft_checker
// Port-level checks on the time base result stream, bound to the top level.
// ----------------------------------------------------------------------------
module tsft_checker import tsft_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result transfer dropped while stalled");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2:0] != 3'd0) && (m_axis_tdata[2:0] <= 3'd4))
    else $error("slot out of range");

  a_frame18: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[23] == (m_axis_tdata[7:3] == 5'd18)) &&
                      (m_axis_tdata[26] == (m_axis_tdata[21:17] == 5'd18)))
    else $error("frame 18 mark inconsistent with frame");

  a_block_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[24] || m_axis_tdata[25]) |-> m_axis_tdata[23])
    else $error("control slot mark outside frame 18");

endmodule

bind tdma_slot_frame_timebase tsft_checker u_tsft_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
